// ===== src/tcc_pkg.sv =====
// Shared types and constants of the text console cursor and scroll engine.
package tcc_pkg;

	localparam int CHAR_W = 7;

	// Opcodes carried on the input tuser bit.
	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	// Character codes.
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;

	localparam int TAB_STEP = 4;
	localparam int TAB_MASK = 3;

	// Configuration register indexes.
	localparam logic [0:0] REG_COLUMNS = 1'b0;
	localparam logic [0:0] REG_ROWS    = 1'b1;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_COPY  = 5'b00100,
		ST_ZERO  = 5'b01000,
		ST_DONE  = 5'b10000
	} tcc_state_t;

	typedef struct packed {
		logic store;
		logic scroll;
	} tcc_put_flags_t;

endpackage

// ===== src/text_console_cursor_scroll_top.sv =====
// Top level of the text console engine: control sequencer around the character grid RAM.
//
// Channel  Dir  Handshake            Payload
// s_*      in   s_tvalid/s_tready    tdata: char_code, read_row, read_col; tuser: opcode;
//                                    tlast: last_of_write
// m_*      out  m_tvalid/m_tready    tdata: cursor_col, cursor_row, read_char, scrolled;
//                                    tlast: end_of_write
// cfg_*    in   cfg_we               cfg_index selects columns (0) or rows (1), cfg_data
//
// A read or a put without scroll is accepted in ST_IDLE and loads the result in ST_DONE.
// A put that scrolls moves each row below the top one up a row through the grid RAM's read and
// write ports, one cell per cycle, then the bottom row is zeroed one cell per cycle.
// After reset a clearing pass writes zero to all MAX_ROWS * 2**clog2(MAX_COLS) cells
// (8192 by default) before the first transfer is accepted.
// A new item is accepted while a result waits in the output register; the block stalls
// in ST_DONE only when the next result is ready and the output register is still full.
module text_console_cursor_scroll_top #(
	parameter int MAX_COLS = 128,
	parameter int MAX_ROWS = 64
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [7:0] char_code, [13:8] read_row, [20:14] read_col
	input  logic        s_tuser,   // [0] opcode
	input  logic        s_tlast,

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [6:0] cursor_col, [12:7] cursor_row,
	                               // [19:13] read_char, [20] scrolled
	output logic        m_tlast,

	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int CLW    = $clog2(MAX_COLS);
	localparam int RW     = $clog2(MAX_ROWS);
	localparam int NCW    = $clog2(MAX_COLS + 1);
	localparam int NRW    = $clog2(MAX_ROWS + 1);
	localparam int NW     = CLW + 1;
	localparam int AW     = RW + CLW;
	localparam int DEPTH  = MAX_ROWS << CLW;
	localparam int NC_RST = (80 > MAX_COLS) ? MAX_COLS : 80;
	localparam int NR_RST = (25 > MAX_ROWS) ? MAX_ROWS : 25;

	tcc_pkg::tcc_state_t     state_q;
	tcc_pkg::tcc_put_flags_t flags;

	logic [NCW-1:0] nc_q;
	logic [NRW-1:0] nr_q;
	logic [CLW-1:0] cur_col_q;
	logic [RW-1:0]  cur_row_q;
	logic [CLW-1:0] next_col;
	logic [RW-1:0]  next_row;

	logic [AW-1:0]  clr_q;
	logic [RW-1:0]  sr_q;
	logic [CLW-1:0] sc_q;
	logic           cp_vld_s1;
	logic [AW-1:0]  cp_addr_s1;

	logic           op_q;
	logic           last_q;
	logic           scr_q;
	logic           rd_ok_q;
	logic [AW-1:0]  rd_addr_q;

	logic                       m_tvalid_q;
	logic [23:0]                m_tdata_q;
	logic                       m_tlast_q;

	logic [7:0]     in_char;
	logic [5:0]     in_row;
	logic [6:0]     in_col;
	logic [AW-1:0]  in_addr;
	logic           in_rd_ok;
	logic           acc;
	logic [CLW-1:0] last_col;
	logic [RW-1:0]  last_row;
	logic           out_free;

	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [tcc_pkg::CHAR_W-1:0] ram_wdata;
	logic [AW-1:0]              ram_raddr;
	logic [tcc_pkg::CHAR_W-1:0] ram_rdata;
	logic [tcc_pkg::CHAR_W-1:0] rchar;

	assign in_char  = s_tdata[7:0];
	assign in_row   = s_tdata[13:8];
	assign in_col   = s_tdata[20:14];
	assign in_addr  = {RW'(in_row), CLW'(in_col)};
	assign in_rd_ok = (32'(in_row) < 32'(nr_q)) && (32'(in_col) < 32'(nc_q));
	assign s_tready = (state_q == tcc_pkg::ST_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign last_col = CLW'(nc_q - NCW'(1));
	assign last_row = RW'(nr_q - NRW'(1));
	assign out_free = !m_tvalid_q || m_tready;

	tcc_cursor #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_cursor (
		.char_code(in_char),
		.col      (cur_col_q),
		.row      (cur_row_q),
		.nc       (nc_q),
		.nr       (nr_q),
		.next_col (next_col),
		.next_row (next_row),
		.flags    (flags)
	);

	tcc_ram #(
		.WIDTH(tcc_pkg::CHAR_W),
		.DEPTH(DEPTH)
	) u_grid (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Grid write port: the copy pipeline has priority over the bottom-row clear.
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = in_addr;
		ram_wdata = '0;
		if (cp_vld_s1) begin
			ram_we = 1'b1;
			ram_waddr = cp_addr_s1;
			ram_wdata = ram_rdata;
		end else begin
			unique case (state_q)
				tcc_pkg::ST_CLEAR: begin
					ram_we = 1'b1;
					ram_waddr = clr_q;
				end
				tcc_pkg::ST_ZERO: begin
					ram_we = 1'b1;
					ram_waddr = {last_row, sc_q};
				end
				tcc_pkg::ST_IDLE: begin
					ram_we = acc && (s_tuser == tcc_pkg::OP_PUT) && flags.store;
					ram_waddr = {cur_row_q, cur_col_q};
					ram_wdata = in_char[tcc_pkg::CHAR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (state_q)
			tcc_pkg::ST_COPY: ram_raddr = {sr_q + RW'(1), sc_q};
			tcc_pkg::ST_DONE: ram_raddr = rd_addr_q;
			default:          ram_raddr = in_addr;
		endcase
	end

	assign rchar = (op_q == tcc_pkg::OP_READ && rd_ok_q) ? ram_rdata : '0;

	// Configuration, clamped to the supported range when written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nc_q <= NCW'(NC_RST);
			nr_q <= NRW'(NR_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				tcc_pkg::REG_COLUMNS: begin
					if (cfg_data == 8'd0) begin
						nc_q <= NCW'(1);
					end else if (32'(cfg_data) > 32'(MAX_COLS)) begin
						nc_q <= NCW'(MAX_COLS);
					end else begin
						nc_q <= NCW'(cfg_data);
					end
				end
				tcc_pkg::REG_ROWS: begin
					if (cfg_data[6:0] == 7'd0) begin
						nr_q <= NRW'(1);
					end else if (32'(cfg_data[6:0]) > 32'(MAX_ROWS)) begin
						nr_q <= NRW'(MAX_ROWS);
					end else begin
						nr_q <= NRW'(cfg_data[6:0]);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= tcc_pkg::ST_CLEAR;
			clr_q      <= '0;
			cur_col_q  <= '0;
			cur_row_q  <= '0;
			sr_q       <= '0;
			sc_q       <= '0;
			cp_vld_s1  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			cp_vld_s1 <= (state_q == tcc_pkg::ST_COPY);
			// load a new result or drop the one taken by the sink
			if (state_q == tcc_pkg::ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				tcc_pkg::ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= tcc_pkg::ST_IDLE;
					end
				end
				tcc_pkg::ST_IDLE: begin
					if (acc) begin
						sr_q <= '0;
						sc_q <= '0;
						if (s_tuser == tcc_pkg::OP_READ) begin
							state_q <= tcc_pkg::ST_DONE;
						end else begin
							cur_col_q <= next_col;
							cur_row_q <= next_row;
							if (!flags.scroll) begin
								state_q <= tcc_pkg::ST_DONE;
							end else if (last_row == '0) begin
								state_q <= tcc_pkg::ST_ZERO;
							end else begin
								state_q <= tcc_pkg::ST_COPY;
							end
						end
					end
				end
				tcc_pkg::ST_COPY: begin
					if (sc_q == last_col) begin
						sc_q <= '0;
						if (sr_q + RW'(1) == last_row) begin
							state_q <= tcc_pkg::ST_ZERO;
						end else begin
							sr_q <= sr_q + RW'(1);
						end
					end else begin
						sc_q <= sc_q + CLW'(1);
					end
				end
				tcc_pkg::ST_ZERO: begin
					// hold while the last copied cell drains through the write port
					if (!cp_vld_s1) begin
						if (sc_q == last_col) begin
							state_q <= tcc_pkg::ST_DONE;
						end else begin
							sc_q <= sc_q + CLW'(1);
						end
					end
				end
				tcc_pkg::ST_DONE: begin
					if (out_free) begin
						state_q <= tcc_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= tcc_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Item and result payload.
	always_ff @(posedge clk) begin
		if (state_q == tcc_pkg::ST_COPY) begin
			cp_addr_s1 <= {sr_q, sc_q};
		end
		if (acc) begin
			op_q      <= s_tuser;
			last_q    <= s_tlast;
			scr_q     <= (s_tuser == tcc_pkg::OP_PUT) && flags.scroll;
			rd_ok_q   <= in_rd_ok;
			rd_addr_q <= in_addr;
		end
		if (state_q == tcc_pkg::ST_DONE && out_free) begin
			m_tdata_q <= {3'b000, scr_q, rchar, 6'(cur_row_q), 7'(cur_col_q)};
			m_tlast_q <= last_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// A finished put leaves the cursor column inside the configured width.
	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcc_pkg::ST_DONE && op_q == tcc_pkg::OP_PUT) |->
			(NW'(cur_col_q) < NW'(nc_q)))
		else $error("cursor column beyond configured columns after put");

	// Copy writes only come from a copy read in the previous cycle.
	a_copy_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		cp_vld_s1 |-> ($past(state_q) == tcc_pkg::ST_COPY) &&
			(state_q == tcc_pkg::ST_COPY || state_q == tcc_pkg::ST_ZERO))
		else $error("copy write outside scroll sequence");

	// A put that does not scroll finishes in the following cycle.
	a_put_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && s_tuser == tcc_pkg::OP_PUT && !flags.scroll) |=>
			(state_q == tcc_pkg::ST_DONE))
		else $error("put without scroll did not finish next cycle");

	// A scroll always ends with the cursor on the bottom row.
	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcc_pkg::ST_DONE && scr_q && op_q == tcc_pkg::OP_PUT) |->
			(cur_row_q == last_row))
		else $error("cursor not on bottom row after scroll");

endmodule

// ===== src/tcc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module tcc_ram #(
	parameter int WIDTH = 7,
	parameter int DEPTH = 8192,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/tcc_cursor.sv =====
// Next-cursor logic for one put: character decode, wrap and scroll detection.
module tcc_cursor #(
	parameter int MAX_COLS = 128,
	parameter int MAX_ROWS = 64,
	localparam int CLW = $clog2(MAX_COLS),
	localparam int RW  = $clog2(MAX_ROWS),
	localparam int NCW = $clog2(MAX_COLS + 1),
	localparam int NRW = $clog2(MAX_ROWS + 1)
) (
	input  logic [7:0]              char_code,
	input  logic [CLW-1:0]          col,
	input  logic [RW-1:0]           row,
	input  logic [NCW-1:0]          nc,
	input  logic [NRW-1:0]          nr,
	output logic [CLW-1:0]          next_col,
	output logic [RW-1:0]           next_row,
	output tcc_pkg::tcc_put_flags_t flags
);

	localparam int NW  = CLW + 1;
	localparam int RW1 = RW + 1;

	logic [NW-1:0]  ncol;
	logic [RW1-1:0] nrow;

	always_comb begin
		ncol = NW'(col);
		nrow = RW1'(row);
		flags.store = 1'b0;
		flags.scroll = 1'b0;
		if (char_code >= tcc_pkg::CH_SPACE && char_code <= tcc_pkg::CH_TILDE) begin
			flags.store = (NW'(col) < NW'(nc)) && (RW1'(row) < RW1'(nr));
			ncol = NW'(col) + NW'(1);
		end else begin
			unique case (char_code)
				tcc_pkg::CH_BS: begin
					if (col != '0) begin
						ncol = NW'(col) - NW'(1);
					end
				end
				tcc_pkg::CH_TAB: begin
					ncol = (NW'(col) + NW'(tcc_pkg::TAB_STEP)) & ~NW'(tcc_pkg::TAB_MASK);
				end
				tcc_pkg::CH_LF: begin
					ncol = '0;
					nrow = RW1'(row) + RW1'(1);
				end
				tcc_pkg::CH_CR: begin
					ncol = '0;
				end
				default: begin
				end
			endcase
		end

		// wrap past the last column
		if (ncol >= NW'(nc)) begin
			ncol = '0;
			nrow = nrow + RW1'(1);
		end

		// past the last row: pin to the bottom row and request a scroll
		if (nrow >= RW1'(nr)) begin
			flags.scroll = 1'b1;
			nrow = RW1'(nr) - RW1'(1);
		end
	end

	assign next_col = CLW'(ncol);
	assign next_row = RW'(nrow);

endmodule
